// ----- sv/lcgc_pkg.sv -----
// Package for the level-crossing gate controller: codes, state and action types.
`default_nettype none

package lcgc_pkg;

	// Event codes carried by an input transaction
	typedef enum logic [2:0] {
		OP_APPROACH    = 3'd0,
		OP_ENTER       = 3'd1,
		OP_EXIT        = 3'd2,
		OP_GATE_CLOSED = 3'd3,
		OP_GATE_OPENED = 3'd4,
		OP_TIMER       = 3'd5,
		OP_INJECT      = 3'd6,
		OP_RESET_FAULT = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		G_OPEN    = 3'd0,
		G_CLOSING = 3'd1,
		G_CLOSED  = 3'd2,
		G_OPENING = 3'd3,
		G_FAULT   = 3'd4
	} gate_t;

	typedef enum logic [1:0] {
		TRK_NONE    = 2'd0,
		TRK_APPR    = 2'd1,
		TRK_ON      = 2'd2,
		TRK_CLEARED = 2'd3
	} track_t;

	typedef enum logic [2:0] {
		FLT_NONE        = 3'd0,
		FLT_CLOSE_TMO   = 3'd1,
		FLT_OPEN_TMO    = 3'd2,
		FLT_UNEXPECTED  = 3'd3,
		FLT_TRAIN_TMO   = 3'd4,
		FLT_TRAIN_EARLY = 3'd5,
		FLT_INJECTED    = 3'd6
	} fault_t;

	typedef enum logic [2:0] {
		TM_CDELAY   = 3'd0,
		TM_CTIMEOUT = 3'd1,
		TM_OTIMEOUT = 3'd2,
		TM_TRAIN    = 3'd3,
		TM_NONE     = 3'd4
	} timer_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_CLOSE = 2'd1,
		CMD_OPEN  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		NTF_NONE    = 2'd0,
		NTF_PREEMPT = 2'd1,
		NTF_CLEAR   = 2'd2
	} notify_t;

	// Timer slot indices (generation counters, cancel mask bits)
	localparam logic [1:0] TIX_CDELAY   = 2'd0;
	localparam logic [1:0] TIX_CTIMEOUT = 2'd1;
	localparam logic [1:0] TIX_OTIMEOUT = 2'd2;
	localparam logic [1:0] TIX_TRAIN    = 2'd3;

	// Configuration register indices and reset values
	localparam logic [1:0] CFG_CLOSE_DELAY   = 2'd0;
	localparam logic [1:0] CFG_CLOSE_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_OPEN_TIMEOUT  = 2'd2;
	localparam logic [1:0] CFG_TRAIN_TIMEOUT = 2'd3;
	localparam logic [7:0] CFG_CLOSE_DELAY_RST   = 8'd3;
	localparam logic [7:0] CFG_CLOSE_TIMEOUT_RST = 8'd10;
	localparam logic [7:0] CFG_OPEN_TIMEOUT_RST  = 8'd10;
	localparam logic [7:0] CFG_TRAIN_TIMEOUT_RST = 8'd60;

	// Controller state, apart from the timer generations
	typedef struct packed {
		gate_t  gate;
		track_t trk_up;
		track_t trk_dn;
		logic   flash;
		fault_t fault;
		logic   reopen;
	} ctl_t;

	// Per-event actions: pulses plus generation increments per timer
	typedef struct packed {
		cmd_t            cmd;
		timer_t          start_id;
		logic [3:0]      cancel;
		notify_t         notify;
		logic            alert;
		logic [3:0][1:0] inc;
	} act_t;

endpackage

`default_nettype wire

// ----- sv/lcgc_fsm.sv -----
// Event decoder: next controller state and action pulses for one event.
`default_nettype none

module lcgc_fsm (
	input  lcgc_pkg::ctl_t ctl,
	input  lcgc_pkg::op_t  op,
	input  logic [1:0]     target,
	input  logic           gen_match,
	output lcgc_pkg::ctl_t nxt,
	output lcgc_pkg::act_t act
);

	lcgc_pkg::track_t trk_sel;
	lcgc_pkg::track_t trk_oth;
	logic             is_track;
	logic             oth_idle;
	logic             go_fault;
	lcgc_pkg::fault_t fault_code;

	assign is_track = ~target[1];
	assign trk_sel  = target[0] ? ctl.trk_dn : ctl.trk_up;
	assign trk_oth  = target[0] ? ctl.trk_up : ctl.trk_dn;
	assign oth_idle = (trk_oth == lcgc_pkg::TRK_NONE) || (trk_oth == lcgc_pkg::TRK_CLEARED);

	// Main decode; a fault entry is folded in at the end
	always_comb begin
		nxt          = ctl;
		act          = '0;
		act.start_id = lcgc_pkg::TM_NONE;
		go_fault     = 1'b0;
		fault_code   = lcgc_pkg::FLT_NONE;
		if ((ctl.fault == lcgc_pkg::FLT_NONE) || (op == lcgc_pkg::OP_RESET_FAULT)) begin
			case (op)
				lcgc_pkg::OP_APPROACH: begin
					if (is_track && (trk_sel == lcgc_pkg::TRK_NONE)) begin
						if (target[0]) nxt.trk_dn = lcgc_pkg::TRK_APPR;
						else nxt.trk_up = lcgc_pkg::TRK_APPR;
						nxt.flash  = 1'b1;
						act.notify = lcgc_pkg::NTF_PREEMPT;
						if (ctl.gate == lcgc_pkg::G_OPEN) begin
							act.start_id                  = lcgc_pkg::TM_CDELAY;
							act.inc[lcgc_pkg::TIX_CDELAY] = 2'd1;
						end
					end
				end
				lcgc_pkg::OP_ENTER: begin
					if (is_track && (trk_sel == lcgc_pkg::TRK_APPR)) begin
						if (ctl.gate != lcgc_pkg::G_CLOSED) begin
							go_fault   = 1'b1;
							fault_code = lcgc_pkg::FLT_TRAIN_EARLY;
						end else begin
							if (target[0]) nxt.trk_dn = lcgc_pkg::TRK_ON;
							else nxt.trk_up = lcgc_pkg::TRK_ON;
							act.start_id                 = lcgc_pkg::TM_TRAIN;
							act.inc[lcgc_pkg::TIX_TRAIN] = 2'd1;
						end
					end
				end
				lcgc_pkg::OP_EXIT: begin
					if (is_track && (trk_sel == lcgc_pkg::TRK_ON)) begin
						if (target[0]) nxt.trk_dn = lcgc_pkg::TRK_CLEARED;
						else nxt.trk_up = lcgc_pkg::TRK_CLEARED;
						act.inc[lcgc_pkg::TIX_TRAIN]    = 2'd1;
						act.cancel[lcgc_pkg::TIX_TRAIN] = 1'b1;
						if (oth_idle) begin
							nxt.trk_up = lcgc_pkg::TRK_NONE;
							nxt.trk_dn = lcgc_pkg::TRK_NONE;
							// Open only from closed or closing
							if ((ctl.gate == lcgc_pkg::G_CLOSED) ||
								(ctl.gate == lcgc_pkg::G_CLOSING)) begin
								nxt.gate                           = lcgc_pkg::G_OPENING;
								act.cmd                            = lcgc_pkg::CMD_OPEN;
								act.inc[lcgc_pkg::TIX_CDELAY]      = 2'd1;
								act.inc[lcgc_pkg::TIX_CTIMEOUT]    = 2'd1;
								act.cancel[lcgc_pkg::TIX_CDELAY]   = 1'b1;
								act.cancel[lcgc_pkg::TIX_CTIMEOUT] = 1'b1;
								act.start_id                       = lcgc_pkg::TM_OTIMEOUT;
								act.inc[lcgc_pkg::TIX_OTIMEOUT]    = 2'd1;
							end
						end
					end
				end
				lcgc_pkg::OP_GATE_CLOSED: begin
					if (ctl.gate == lcgc_pkg::G_CLOSING) begin
						nxt.gate                           = lcgc_pkg::G_CLOSED;
						act.inc[lcgc_pkg::TIX_CTIMEOUT]    = 2'd1;
						act.cancel[lcgc_pkg::TIX_CTIMEOUT] = 1'b1;
						// Pending reopen after a fault reset: close timeout generation advances by two
						if (ctl.reopen) begin
							nxt.reopen                       = 1'b0;
							nxt.gate                         = lcgc_pkg::G_OPENING;
							act.cmd                          = lcgc_pkg::CMD_OPEN;
							act.inc[lcgc_pkg::TIX_CDELAY]    = 2'd1;
							act.inc[lcgc_pkg::TIX_CTIMEOUT]  = 2'd2;
							act.cancel[lcgc_pkg::TIX_CDELAY] = 1'b1;
							act.start_id                     = lcgc_pkg::TM_OTIMEOUT;
							act.inc[lcgc_pkg::TIX_OTIMEOUT]  = 2'd1;
						end
					end
				end
				lcgc_pkg::OP_GATE_OPENED: begin
					if (ctl.gate == lcgc_pkg::G_OPENING) begin
						nxt.gate                           = lcgc_pkg::G_OPEN;
						nxt.flash                          = 1'b0;
						act.notify                         = lcgc_pkg::NTF_CLEAR;
						act.inc[lcgc_pkg::TIX_OTIMEOUT]    = 2'd1;
						act.cancel[lcgc_pkg::TIX_OTIMEOUT] = 1'b1;
					end
				end
				lcgc_pkg::OP_TIMER: begin
					if (gen_match) begin
						case (target)
							lcgc_pkg::TIX_CDELAY: begin
								if ((ctl.gate == lcgc_pkg::G_OPEN) ||
									(ctl.gate == lcgc_pkg::G_OPENING)) begin
									nxt.gate                        = lcgc_pkg::G_CLOSING;
									act.cmd                         = lcgc_pkg::CMD_CLOSE;
									act.start_id                    = lcgc_pkg::TM_CTIMEOUT;
									act.inc[lcgc_pkg::TIX_CTIMEOUT] = 2'd1;
								end
							end
							lcgc_pkg::TIX_CTIMEOUT: begin
								go_fault   = 1'b1;
								fault_code = lcgc_pkg::FLT_CLOSE_TMO;
							end
							lcgc_pkg::TIX_OTIMEOUT: begin
								go_fault   = 1'b1;
								fault_code = lcgc_pkg::FLT_OPEN_TMO;
							end
							default: begin
								go_fault   = 1'b1;
								fault_code = lcgc_pkg::FLT_TRAIN_TMO;
							end
						endcase
					end
				end
				lcgc_pkg::OP_INJECT: begin
					go_fault   = 1'b1;
					fault_code = lcgc_pkg::FLT_INJECTED;
				end
				lcgc_pkg::OP_RESET_FAULT: begin
					if (ctl.fault != lcgc_pkg::FLT_NONE) begin
						nxt.fault                       = lcgc_pkg::FLT_NONE;
						nxt.trk_up                      = lcgc_pkg::TRK_NONE;
						nxt.trk_dn                      = lcgc_pkg::TRK_NONE;
						nxt.gate                        = lcgc_pkg::G_CLOSING;
						nxt.reopen                      = 1'b1;
						act.cmd                         = lcgc_pkg::CMD_CLOSE;
						act.start_id                    = lcgc_pkg::TM_CTIMEOUT;
						act.inc[lcgc_pkg::TIX_CTIMEOUT] = 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
		// Fault entry: every timer cancelled once, lights on
		if (go_fault) begin
			nxt.fault  = fault_code;
			nxt.gate   = lcgc_pkg::G_FAULT;
			nxt.flash  = 1'b1;
			act.cancel = 4'hF;
			act.inc    = {4{2'd1}};
			act.alert  = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- sv/lcgc_tgen.sv -----
// Timer generation counters: stale-expiry check and tag of a started timer.
`default_nettype none

module lcgc_tgen #(
	parameter int GEN_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    upd,
	input  logic [3:0][1:0]         inc,
	input  logic [1:0]              target,
	input  logic [31:0]             event_gen,
	input  lcgc_pkg::timer_t        start_id,
	output logic                    gen_match,
	output logic [31:0]             start_gen
);

	logic [GEN_WIDTH-1:0] gen_q   [4];
	logic [GEN_WIDTH-1:0] gen_nxt [4];

	// Generations after this event, wrapping at GEN_WIDTH bits
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			gen_nxt[i] = gen_q[i] + GEN_WIDTH'(inc[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				gen_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < 4; i++) begin
				gen_q[i] <= gen_nxt[i];
			end
		end
	end

	// The full 32-bit tag must match the zero-extended generation
	assign gen_match = (32'(gen_q[target]) == event_gen);
	assign start_gen = (start_id == lcgc_pkg::TM_NONE) ? 32'd0 : 32'(gen_nxt[start_id[1:0]]);

endmodule

`default_nettype wire

// ----- sv/level_crossing_gate_controller.sv -----
// Top level of the level-crossing gate controller: handshakes, state and result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser = op, s_tdata = target, event_gen
//  m_*       out  m_tvalid/m_tready  m_tdata = states, commands, timer request
//  cfg_*     in   cfg_we             cfg_index, cfg_data (timer durations)
//
//  One transaction per cycle sustained while m_tready is high; an accepted event passes
//  through the input register, then the result register, before it is presented.
//  State and generations update in the cycle an event moves into the result register.
//  arst_n clears control state, generations and the duration registers to their defaults.
//  A stalled m_tready holds the result; the input register still takes one more event.
`default_nettype none

module level_crossing_gate_controller #(
	parameter int GEN_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // [2:0] op
	input  logic [39:0] s_tdata,   // [1:0] target, [33:2] event_gen, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] gate_state, [4:3] up_track_state, [6:5] down_track_state, [7] flash_lights,
	// [10:8] fault_code, [12:11] gate cmd, [15:13] timer id,
	// [47:16] timer tag, [55:48] timer seconds, [59:56] cancel mask,
	// [61:60] notify, [62] alert pulse, [63] zero
	output logic [63:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// Input register
	logic                 valid_s1;
	lcgc_pkg::op_t        op_s1;
	logic [1:0]           target_s1;
	logic [31:0]          gen_s1;
	logic                 s_accept;
	logic                 advance;

	// State and decode
	lcgc_pkg::ctl_t       ctl_q;
	lcgc_pkg::ctl_t       ctl_nxt;
	lcgc_pkg::act_t       act;
	logic                 gen_match;
	logic [31:0]          start_gen;
	logic [7:0]           cfg_q [4];
	logic [7:0]           start_secs;

	// Result register
	logic                 valid_s2;
	lcgc_pkg::ctl_t       ctl_s2;
	lcgc_pkg::act_t       act_s2;
	logic [31:0]          tgen_s2;
	logic [7:0]           tsec_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_s1     <= lcgc_pkg::op_t'(s_tuser);
			target_s1 <= s_tdata[1:0];
			gen_s1    <= s_tdata[33:2];
		end
	end

	// Duration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[lcgc_pkg::CFG_CLOSE_DELAY]   <= lcgc_pkg::CFG_CLOSE_DELAY_RST;
			cfg_q[lcgc_pkg::CFG_CLOSE_TIMEOUT] <= lcgc_pkg::CFG_CLOSE_TIMEOUT_RST;
			cfg_q[lcgc_pkg::CFG_OPEN_TIMEOUT]  <= lcgc_pkg::CFG_OPEN_TIMEOUT_RST;
			cfg_q[lcgc_pkg::CFG_TRAIN_TIMEOUT] <= lcgc_pkg::CFG_TRAIN_TIMEOUT_RST;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Event decode
	lcgc_fsm u_fsm (
		.ctl       (ctl_q),
		.op        (op_s1),
		.target    (target_s1),
		.gen_match (gen_match),
		.nxt       (ctl_nxt),
		.act       (act)
	);

	lcgc_tgen #(
		.GEN_WIDTH (GEN_WIDTH)
	) u_tgen (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance),
		.inc       (act.inc),
		.target    (target_s1),
		.event_gen (gen_s1),
		.start_id  (act.start_id),
		.gen_match (gen_match),
		.start_gen (start_gen)
	);

	assign start_secs = (act.start_id == lcgc_pkg::TM_NONE) ? 8'd0 : cfg_q[act.start_id[1:0]];

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.gate   <= lcgc_pkg::G_OPEN;
			ctl_q.trk_up <= lcgc_pkg::TRK_NONE;
			ctl_q.trk_dn <= lcgc_pkg::TRK_NONE;
			ctl_q.flash  <= 1'b0;
			ctl_q.fault  <= lcgc_pkg::FLT_NONE;
			ctl_q.reopen <= 1'b0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctl_s2  <= ctl_nxt;
			act_s2  <= act;
			tgen_s2 <= start_gen;
			tsec_s2 <= start_secs;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, act_s2.alert, act_s2.notify, act_s2.cancel, tsec_s2, tgen_s2,
		act_s2.start_id, act_s2.cmd, ctl_s2.fault, ctl_s2.flash, ctl_s2.trk_dn,
		ctl_s2.trk_up, ctl_s2.gate};

`ifndef SYNTHESIS
	// Gate shows fault exactly while a fault code is held
	a_fault_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.fault != lcgc_pkg::FLT_NONE) == (ctl_q.gate == lcgc_pkg::G_FAULT))
		else $error("fault code and gate state disagree");

	// A fault alert cancels all timers and leaves the gate faulted with lights on
	a_alert: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && act_s2.alert) |->
		(act_s2.cancel == 4'hF) && (ctl_s2.gate == lcgc_pkg::G_FAULT) && ctl_s2.flash)
		else $error("fault alert without full fault entry");

	// No timer started means zero tag and zero duration
	a_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (act_s2.start_id == lcgc_pkg::TM_NONE)) |->
		(tgen_s2 == 32'd0) && (tsec_s2 == 8'd0))
		else $error("timer tag or duration without a start");

	// A waiting input event is neither lost nor changed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(gen_s1) && $stable(target_s1))
		else $error("input register dropped or changed a waiting event");

	// State only moves when an event is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(ctl_q))
		else $error("controller state changed without an event");
`endif

endmodule

`default_nettype wire
